FILE: hw/rtl/fwsk_pkg.sv
// Shared types, constants and helpers for the four-wheel steering kinematics block.
// No dependencies; used by every RTL file in this folder.
`default_nettype none
package fwsk_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int DIV_STEPS  = 30;
  localparam int SQRT_STEPS = 31;
  localparam int CX_W = 35;
  localparam int CZ_W = 33;

  localparam logic signed [33:0] PI_Q30   = 34'sd3373259426;
  localparam logic signed [33:0] PI3_Q30  = 34'sd1124419809;
  localparam logic signed [15:0] PI4_Q13  = 16'sd6434;

  localparam logic [1:0] REG_INV_WHEEL_RADIUS = 2'd0;
  localparam logic [1:0] REG_AXLE_DIST        = 2'd1;
  localparam logic [1:0] REG_SPIN_RADIUS      = 2'd2;

  typedef enum logic [1:0] {
    MODE_STOP      = 2'd0,
    MODE_SPIN      = 2'd1,
    MODE_CURVE     = 2'd2,
    MODE_TRANSLATE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [45:0] rem;
    logic [16:0] d;
    logic [29:0] q;
  } div_t;

  typedef struct packed {
    logic [61:0] v;
    logic [61:0] r;
  } sqrt_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } cvec_t;

  typedef struct packed {
    mode_t              mode;
    logic               wz_pos;
    logic               vx_neg;
    logic               vy_neg;
    logic [15:0]        ax;
    logic [15:0]        ay;
    logic signed [20:0] spd_c;
    logic signed [48:0] p2;
    logic               ovf;
    logic [31:0]        sq;
    logic [29:0]        s;
    logic               sat;
    logic [41:0]        prod;
  } ctx_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] rsh(input logic signed [63:0] v, input int s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [20:0] sat21(input logic signed [63:0] v);
    logic signed [20:0] r;
    if (v > 64'sd1048575) r = 21'sd1048575;
    else if (v < -64'sd1048576) r = -21'sd1048576;
    else r = 21'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/fwsk_div_cell.sv
// One restoring division step: produces one quotient bit per cycle.
// Depends on fwsk_pkg.
`default_nettype none
module fwsk_div_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic          clk,
  input  fwsk_pkg::div_t     d_in,
  output fwsk_pkg::div_t     d_out
);

  logic [46:0]    dsh;
  fwsk_pkg::div_t d_nxt;

  assign dsh = {30'b0, d_in.d} << SHIFT;

  always_comb begin
    d_nxt = d_in;
    if ({1'b0, d_in.rem} >= dsh) begin
      d_nxt.rem = d_in.rem - dsh[45:0];
      d_nxt.q   = d_in.q | (30'd1 << SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    d_out <= d_nxt;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fwsk_sqrt_cell.sv
// One integer square root step: retires one root bit per cycle.
// Depends on fwsk_pkg.
`default_nettype none
module fwsk_sqrt_cell #(
  parameter int K = 0
) (
  input  wire logic          clk,
  input  fwsk_pkg::sqrt_t    s_in,
  output fwsk_pkg::sqrt_t    s_out
);

  localparam logic [61:0] BIT = 62'd1 << (2 * K);

  logic [61:0]     t;
  fwsk_pkg::sqrt_t s_nxt;

  assign t = s_in.r + BIT;

  always_comb begin
    s_nxt = s_in;
    if (s_in.v >= t) begin
      s_nxt.v = s_in.v - t;
      s_nxt.r = (s_in.r >> 1) + BIT;
    end else begin
      s_nxt.r = s_in.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    s_out <= s_nxt;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fwsk_cordic_cell.sv
// One vectoring CORDIC micro-rotation toward y = 0.
// Depends on fwsk_pkg (angle table, vector type).
`default_nettype none
module fwsk_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  fwsk_pkg::cvec_t    c_in,
  output fwsk_pkg::cvec_t    c_out
);

  localparam logic signed [fwsk_pkg::CZ_W-1:0] ANG =
    $signed({1'b0, fwsk_pkg::atan_q30(IDX)});

  logic signed [fwsk_pkg::CX_W-1:0] dx;
  logic signed [fwsk_pkg::CX_W-1:0] dy;
  fwsk_pkg::cvec_t                  c_nxt;

  assign dx = c_in.y >>> IDX;
  assign dy = c_in.x >>> IDX;

  always_comb begin
    c_nxt = c_in;
    if (c_in.y > 0) begin
      c_nxt.x = c_in.x + dx;
      c_nxt.y = c_in.y - dy;
      c_nxt.z = c_in.z + ANG;
    end else if (c_in.y < 0) begin
      c_nxt.x = c_in.x - dx;
      c_nxt.y = c_in.y + dy;
      c_nxt.z = c_in.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    c_out <= c_nxt;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/four_wheel_steer_kinematics_top.sv
// Top level of the four-wheel steering kinematics block.
// Depends on fwsk_pkg, fwsk_div_cell, fwsk_sqrt_cell, fwsk_cordic_cell.
//
// Usage:
//   A request (in_vel_x, in_vel_y, in_yaw_rate) is taken at a rising edge with
//   start high and busy low. busy is always low: one request per cycle.
//   Each request gives exactly one result, shown for one cycle with out_strobe
//   high. The pipeline runs as a chain of cells: 30 divider cells (curve
//   sine), 31 square root cells (curve cosine or translate magnitude) and two
//   rows of CORDIC_STAGES angle cells, around which sit seven further stages
//   of capture, multipliers and final rounding.
//   The receiver cannot stall; results are never held.
//   Reset clears all request tracking and restores the register defaults;
//   requests in flight are dropped.
//   Registers sit on the APB port at 0x0 (inv_wheel_radius), 0x4 (axle distance)
//   and 0x8 (spin_radius); write them only while no request is in flight.
`default_nettype none
module four_wheel_steer_kinematics_top #(
  parameter int CORDIC_STAGES = fwsk_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_vel_x,
  input  wire logic signed [15:0] in_vel_y,
  input  wire logic signed [15:0] in_yaw_rate,
  output logic                    out_strobe,
  output logic [1:0]              out_drive_mode,
  output logic                    out_steer_valid,
  output logic signed [20:0]      out_speed_front_right,
  output logic signed [20:0]      out_speed_front_left,
  output logic signed [20:0]      out_speed_rear_right,
  output logic signed [20:0]      out_speed_rear_left,
  output logic signed [15:0]      out_steer_front_right,
  output logic signed [15:0]      out_steer_front_left,
  output logic signed [15:0]      out_steer_rear_right,
  output logic signed [15:0]      out_steer_rear_left,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int DN  = fwsk_pkg::DIV_STEPS;
  localparam int SN  = fwsk_pkg::SQRT_STEPS;
  localparam int LAT = 3 + DN + 2 + SN + 2 + CORDIC_STAGES;

  // registers
  logic [15:0] inv_wheel_radius_r;
  logic [15:0] axle_dist_r;
  logic [15:0] spin_radius_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_wheel_radius_r <= 16'd3413;
      axle_dist_r        <= 16'd32768;
      spin_radius_r      <= 16'd23170;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        fwsk_pkg::REG_INV_WHEEL_RADIUS: inv_wheel_radius_r <= pwdata[15:0];
        fwsk_pkg::REG_AXLE_DIST:        axle_dist_r        <= pwdata[15:0];
        fwsk_pkg::REG_SPIN_RADIUS:      spin_radius_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fwsk_pkg::REG_INV_WHEEL_RADIUS: prdata = {16'b0, inv_wheel_radius_r};
      fwsk_pkg::REG_AXLE_DIST:        prdata = {16'b0, axle_dist_r};
      fwsk_pkg::REG_SPIN_RADIUS:      prdata = {16'b0, spin_radius_r};
      default:                        prdata = 32'b0;
    endcase
  end

  // request tracking
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], start & ~busy};
  end

  assign out_strobe = vld_r[LAT-1];

  // stage 1: capture
  logic signed [15:0] vx1_r, vy1_r, wz1_r;

  always_ff @(posedge clk) begin
    vx1_r <= in_vel_x;
    vy1_r <= in_vel_y;
    wz1_r <= in_yaw_rate;
  end

  // stage 2: mode and first products
  fwsk_pkg::mode_t    mode1;
  logic [15:0]        ax1, ay1, aw1;
  fwsk_pkg::mode_t    mode2_r;
  logic               wz_pos2_r, vx_neg2_r, vy_neg2_r;
  logic [15:0]        ax2_r, ay2_r;
  logic [31:0]        n2_r, sqx2_r, sqy2_r;
  logic [16:0]        d2_r;
  logic signed [32:0] p1_2_r, pc2_r;

  assign ax1 = vx1_r[15] ? 16'(-vx1_r) : vx1_r;
  assign ay1 = vy1_r[15] ? 16'(-vy1_r) : vy1_r;
  assign aw1 = wz1_r[15] ? 16'(-wz1_r) : wz1_r;

  always_comb begin
    if (vx1_r == 16'sd0 && vy1_r == 16'sd0 && wz1_r == 16'sd0) mode1 = fwsk_pkg::MODE_STOP;
    else if (vx1_r == 16'sd0 && vy1_r == 16'sd0) mode1 = fwsk_pkg::MODE_SPIN;
    else if (vx1_r != 16'sd0 && wz1_r != 16'sd0) mode1 = fwsk_pkg::MODE_CURVE;
    else mode1 = fwsk_pkg::MODE_TRANSLATE;
  end

  always_ff @(posedge clk) begin
    mode2_r   <= mode1;
    wz_pos2_r <= ~wz1_r[15] && (wz1_r != 16'sd0);
    vx_neg2_r <= vx1_r[15];
    vy_neg2_r <= vy1_r[15];
    ax2_r     <= ax1;
    ay2_r     <= ay1;
    n2_r      <= 32'(axle_dist_r) * 32'(aw1);
    d2_r      <= {ax1, 1'b0};
    sqx2_r    <= 32'(ax1) * 32'(ax1);
    sqy2_r    <= 32'(ay1) * 32'(ay1);
    p1_2_r    <= 33'(wz1_r) * 33'($signed({1'b0, spin_radius_r}));
    pc2_r     <= 33'(vx1_r) * 33'($signed({1'b0, inv_wheel_radius_r}));
  end

  // stage 3: divider setup, spin product, curve speed
  fwsk_pkg::ctx_t     ctx3_nxt, ctx3_r;
  fwsk_pkg::div_t     div3_nxt, div3_r;
  logic [45:0]        num2;
  logic signed [49:0] p2_full;

  assign num2    = {n2_r, 14'b0};
  assign p2_full = 50'(p1_2_r) * 50'($signed({1'b0, inv_wheel_radius_r}));

  always_comb begin
    ctx3_nxt        = '0;
    ctx3_nxt.mode   = mode2_r;
    ctx3_nxt.wz_pos = wz_pos2_r;
    ctx3_nxt.vx_neg = vx_neg2_r;
    ctx3_nxt.vy_neg = vy_neg2_r;
    ctx3_nxt.ax     = ax2_r;
    ctx3_nxt.ay     = ay2_r;
    ctx3_nxt.spd_c  = fwsk_pkg::sat21(fwsk_pkg::rsh(64'(pc2_r), 10));
    ctx3_nxt.p2     = p2_full[48:0];
    ctx3_nxt.ovf    = {1'b0, num2} >= {d2_r, 30'b0};
    ctx3_nxt.sq     = sqx2_r + sqy2_r;
    div3_nxt.rem    = num2;
    div3_nxt.d      = d2_r;
    div3_nxt.q      = '0;
  end

  always_ff @(posedge clk) begin
    ctx3_r <= ctx3_nxt;
    div3_r <= div3_nxt;
  end

  // divider row
  fwsk_pkg::div_t dv [DN+1];
  fwsk_pkg::ctx_t dctx_r [DN];

  assign dv[0] = div3_r;

  for (genvar j = 0; j < DN; j++) begin : g_div
    fwsk_div_cell #(.SHIFT(DN - 1 - j)) u_cell (
      .clk   (clk),
      .d_in  (dv[j]),
      .d_out (dv[j+1])
    );
  end

  always_ff @(posedge clk) begin
    dctx_r[0] <= ctx3_r;
    for (int i = 1; i < DN; i++) dctx_r[i] <= dctx_r[i-1];
  end

  // stage 34: square of the sine
  fwsk_pkg::ctx_t ctx34_nxt, ctx34_r;
  logic [59:0]    ss34_r;

  always_comb begin
    ctx34_nxt   = dctx_r[DN-1];
    ctx34_nxt.s = dv[DN].q;
  end

  always_ff @(posedge clk) begin
    ctx34_r <= ctx34_nxt;
    ss34_r  <= 60'(dv[DN].q) * 60'(dv[DN].q);
  end

  // stage 35: root operand
  fwsk_pkg::ctx_t  ctx35_nxt, ctx35_r;
  fwsk_pkg::sqrt_t sq35_nxt, sq35_r;

  always_comb begin
    ctx35_nxt     = ctx34_r;
    ctx35_nxt.sat = ctx34_r.ovf | ss34_r[59];
    sq35_nxt.r    = '0;
    if (ctx34_r.mode == fwsk_pkg::MODE_CURVE) sq35_nxt.v = (62'd1 << 60) - {2'b0, ss34_r};
    else                                      sq35_nxt.v = {10'b0, ctx34_r.sq, 20'b0};
  end

  always_ff @(posedge clk) begin
    ctx35_r <= ctx35_nxt;
    sq35_r  <= sq35_nxt;
  end

  // square root row
  fwsk_pkg::sqrt_t sv [SN+1];
  fwsk_pkg::ctx_t  sctx_r [SN];

  assign sv[0] = sq35_r;

  for (genvar j = 0; j < SN; j++) begin : g_sqrt
    fwsk_sqrt_cell #(.K(SN - 1 - j)) u_cell (
      .clk   (clk),
      .s_in  (sv[j]),
      .s_out (sv[j+1])
    );
  end

  always_ff @(posedge clk) begin
    sctx_r[0] <= ctx35_r;
    for (int i = 1; i < SN; i++) sctx_r[i] <= sctx_r[i-1];
  end

  // stage 67: angle operands and translate speed product
  fwsk_pkg::ctx_t  ctxs, ctx67_nxt, ctx67_r;
  fwsk_pkg::cvec_t c1_nxt, c2_nxt, c1_67_r, c2_67_r;
  logic [30:0]     root;

  assign ctxs = sctx_r[SN-1];
  assign root = sv[SN].r[30:0];

  always_comb begin
    ctx67_nxt      = ctxs;
    ctx67_nxt.prod = 42'(sv[SN].r[25:0]) * 42'(inv_wheel_radius_r);
    c1_nxt = '0;
    c2_nxt = '0;
    if (ctxs.mode == fwsk_pkg::MODE_CURVE) begin
      if (ctxs.sat) begin
        c2_nxt.x = 35'sd1610612736;
        c2_nxt.y = 35'sd536870912;
      end else begin
        c1_nxt.x = $signed({4'b0, root});
        c1_nxt.y = $signed({5'b0, ctxs.s});
        c2_nxt.x = $signed({4'b0, ctxs.s, 1'b0}) + $signed({4'b0, root});
        c2_nxt.y = $signed({5'b0, ctxs.s});
      end
    end else begin
      c1_nxt.x = $signed({5'b0, ctxs.ax, 14'b0});
      c1_nxt.y = $signed({5'b0, ctxs.ay, 14'b0});
    end
  end

  always_ff @(posedge clk) begin
    ctx67_r <= ctx67_nxt;
    c1_67_r <= c1_nxt;
    c2_67_r <= c2_nxt;
  end

  // CORDIC rows
  fwsk_pkg::cvec_t cv1 [CORDIC_STAGES+1];
  fwsk_pkg::cvec_t cv2 [CORDIC_STAGES+1];
  fwsk_pkg::ctx_t  cctx_r [CORDIC_STAGES];

  assign cv1[0] = c1_67_r;
  assign cv2[0] = c2_67_r;

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
    fwsk_cordic_cell #(.IDX(j)) u_cell_a (
      .clk   (clk),
      .c_in  (cv1[j]),
      .c_out (cv1[j+1])
    );
    fwsk_cordic_cell #(.IDX(j)) u_cell_b (
      .clk   (clk),
      .c_in  (cv2[j]),
      .c_out (cv2[j+1])
    );
  end

  always_ff @(posedge clk) begin
    cctx_r[0] <= ctx67_r;
    for (int i = 1; i < CORDIC_STAGES; i++) cctx_r[i] <= cctx_r[i-1];
  end

  // final stage: rounding, folding, assembly
  fwsk_pkg::ctx_t     cf;
  logic signed [15:0] ang_a, ang_b, th16;
  logic signed [33:0] t34, th34;
  logic               rev;
  logic signed [63:0] vt, vs;
  logic signed [20:0] spd_t, spd_s0, spd_s1;
  logic signed [20:0] spd_nxt [4];
  logic signed [15:0] ang_nxt [4];
  logic               valid_nxt;

  assign cf = cctx_r[CORDIC_STAGES-1];
  assign t34 = 34'(cv1[CORDIC_STAGES].z);

  always_comb begin
    ang_a = cf.sat ? fwsk_pkg::PI4_Q13
                   : 16'(fwsk_pkg::rsh(64'(cv1[CORDIC_STAGES].z), 17));
    ang_b = 16'(fwsk_pkg::rsh(64'(cv2[CORDIC_STAGES].z), 17));

    rev = 1'b0;
    if (!cf.vx_neg) begin
      th34 = cf.vy_neg ? -t34 : t34;
    end else if (t34 < fwsk_pkg::PI3_Q30) begin
      th34 = cf.vy_neg ? t34 : -t34;
      rev  = 1'b1;
    end else begin
      th34 = cf.vy_neg ? t34 - fwsk_pkg::PI_Q30 : fwsk_pkg::PI_Q30 - t34;
    end
    th16 = 16'(fwsk_pkg::rsh(64'(th34), 17));

    vt     = fwsk_pkg::rsh($signed({22'b0, cf.prod}), 20);
    spd_t  = fwsk_pkg::sat21(rev ? -vt : vt);
    vs     = fwsk_pkg::rsh(64'(cf.p2), 26);
    spd_s0 = fwsk_pkg::sat21(vs);
    spd_s1 = fwsk_pkg::sat21(-vs);

    valid_nxt = 1'b1;
    for (int k = 0; k < 4; k++) begin
      spd_nxt[k] = '0;
      ang_nxt[k] = '0;
    end

    case (cf.mode)
      fwsk_pkg::MODE_STOP: begin
        valid_nxt = 1'b0;
      end
      fwsk_pkg::MODE_SPIN: begin
        spd_nxt[0] = spd_s0;
        spd_nxt[2] = spd_s0;
        spd_nxt[1] = spd_s1;
        spd_nxt[3] = spd_s1;
        ang_nxt[0] = fwsk_pkg::PI4_Q13;
        ang_nxt[3] = fwsk_pkg::PI4_Q13;
        ang_nxt[1] = -fwsk_pkg::PI4_Q13;
        ang_nxt[2] = -fwsk_pkg::PI4_Q13;
      end
      fwsk_pkg::MODE_CURVE: begin
        for (int k = 0; k < 4; k++) spd_nxt[k] = cf.spd_c;
        if (cf.wz_pos) begin
          ang_nxt[1] = ang_a;
          ang_nxt[0] = ang_b;
          ang_nxt[3] = -ang_a;
          ang_nxt[2] = -ang_b;
        end else begin
          ang_nxt[0] = -ang_a;
          ang_nxt[1] = -ang_b;
          ang_nxt[2] = ang_b;
          ang_nxt[3] = ang_a;
        end
      end
      default: begin
        for (int k = 0; k < 4; k++) begin
          spd_nxt[k] = spd_t;
          ang_nxt[k] = th16;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_drive_mode        <= cf.mode;
    out_steer_valid       <= valid_nxt;
    out_speed_front_right <= spd_nxt[0];
    out_speed_front_left  <= spd_nxt[1];
    out_speed_rear_right  <= spd_nxt[2];
    out_speed_rear_left   <= spd_nxt[3];
    out_steer_front_right <= ang_nxt[0];
    out_steer_front_left  <= ang_nxt[1];
    out_steer_rear_right  <= ang_nxt[2];
    out_steer_rear_left   <= ang_nxt[3];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fwsk_checker.sv
// Port-level checks on results of the four-wheel steering kinematics block.
// Depends on fwsk_pkg; bound to four_wheel_steer_kinematics_top.
`default_nettype none
module fwsk_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_strobe,
  input wire logic [1:0]         out_drive_mode,
  input wire logic               out_steer_valid,
  input wire logic signed [20:0] out_speed_front_right,
  input wire logic signed [20:0] out_speed_front_left,
  input wire logic signed [20:0] out_speed_rear_right,
  input wire logic signed [20:0] out_speed_rear_left,
  input wire logic signed [15:0] out_steer_front_right,
  input wire logic signed [15:0] out_steer_front_left,
  input wire logic signed [15:0] out_steer_rear_right,
  input wire logic signed [15:0] out_steer_rear_left
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

  a_valid_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_steer_valid == (out_drive_mode != fwsk_pkg::MODE_STOP)))
    else $error("steer_valid disagrees with mode");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_drive_mode == fwsk_pkg::MODE_STOP |->
      out_speed_front_right == 21'sd0 && out_speed_front_left == 21'sd0 &&
      out_speed_rear_right == 21'sd0 && out_speed_rear_left == 21'sd0)
    else $error("stop request with nonzero speed");

  a_spin_angles: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_drive_mode == fwsk_pkg::MODE_SPIN |->
      out_steer_front_right == fwsk_pkg::PI4_Q13 &&
      out_steer_rear_left == fwsk_pkg::PI4_Q13 &&
      out_steer_front_left == -fwsk_pkg::PI4_Q13 &&
      out_steer_rear_right == -fwsk_pkg::PI4_Q13 &&
      out_speed_front_right == out_speed_rear_right)
    else $error("spin result malformed");

  a_curve_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_drive_mode == fwsk_pkg::MODE_CURVE |->
      out_speed_front_right == out_speed_rear_left &&
      out_speed_front_left == out_speed_rear_right &&
      ((out_steer_front_left == -out_steer_rear_left &&
        out_steer_front_right == -out_steer_rear_right) ||
       (out_steer_front_right == -out_steer_rear_left &&
        out_steer_front_left == -out_steer_rear_right)))
    else $error("curve result not mirrored");

endmodule

bind four_wheel_steer_kinematics_top fwsk_checker u_fwsk_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_strobe            (out_strobe),
  .out_drive_mode        (out_drive_mode),
  .out_steer_valid       (out_steer_valid),
  .out_speed_front_right (out_speed_front_right),
  .out_speed_front_left  (out_speed_front_left),
  .out_speed_rear_right  (out_speed_rear_right),
  .out_speed_rear_left   (out_speed_rear_left),
  .out_steer_front_right (out_steer_front_right),
  .out_steer_front_left  (out_steer_front_left),
  .out_steer_rear_right  (out_steer_rear_right),
  .out_steer_rear_left   (out_steer_rear_left)
);
`default_nettype wire
